@@ src/trme_pkg.sv @@
// Shared types, constants and defaults for the register machine execute unit.
`default_nettype none
package trme_pkg;

    localparam int DEF_NUM_REGS    = 32;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_PROG_DEPTH  = 256;

    localparam int DATA_W   = 32;
    localparam int REGIDX_W = 5;
    localparam int TGT_W    = 8;
    localparam int MODE_W   = 5;
    localparam int PLEN_W   = 9;
    localparam logic [PLEN_W-1:0] PLEN_RESET = 9'd256;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 80;

    localparam logic [MODE_W-1:0] MODE_MAX = 5'd18;

    typedef enum logic [MODE_W-1:0] {
        OP_NOP  = 5'd0,
        OP_MOV  = 5'd1,
        OP_INC  = 5'd2,
        OP_DEC  = 5'd3,
        OP_ADD  = 5'd4,
        OP_SUB  = 5'd5,
        OP_MUL  = 5'd6,
        OP_DIV  = 5'd7,
        OP_CMP  = 5'd8,
        OP_JMP  = 5'd9,
        OP_JNE  = 5'd10,
        OP_JE   = 5'd11,
        OP_JGE  = 5'd12,
        OP_JG   = 5'd13,
        OP_JLE  = 5'd14,
        OP_JL   = 5'd15,
        OP_CALL = 5'd16,
        OP_RET  = 5'd17,
        OP_END  = 5'd18
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DIVZ = 2'd1,
        STAT_OVF  = 2'd2,
        STAT_UNF  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                  op;
        logic [REGIDX_W-1:0]  dst_reg;
        logic                 src_is_reg;
        logic [REGIDX_W-1:0]  src_reg;
        logic [DATA_W-1:0]    src_imm;
        logic                 left_is_reg;
        logic [DATA_W-1:0]    left_imm;
        logic [TGT_W-1:0]     target;
    } item_t;

endpackage
`default_nettype wire

@@ src/toy_register_machine_execute_unit.sv @@
// Top level of the register machine execute unit: front end, queue and back end.
// An instruction passes through the queue, register read, operand latch and execute;
// a divide by a nonzero value also runs the one-bit-per-cycle divider. The back end
// runs one instruction at a time and takes the next once the last has committed.
// Reset (rst_n, async low): registers and stack read as zero, pc 0, one stack entry.
`default_nettype none
module toy_register_machine_execute_unit
#(
    parameter int NUM_REGS    = trme_pkg::DEF_NUM_REGS,
    parameter int STACK_DEPTH = trme_pkg::DEF_STACK_DEPTH,
    parameter int PROG_DEPTH  = trme_pkg::DEF_PROG_DEPTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // instruction transactions
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // mode[4:0] dst_reg[9:5] src_is_reg[10] src_reg[15:11] src_imm[47:16]
    // left_is_reg[48] left_imm[80:49] target[88:81], rest zero
    input  wire logic [trme_pkg::IN_TDATA_W-1:0]   s_tdata,
    // program_length writes, taken any cycle
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [trme_pkg::PLEN_W-1:0]       cfg_data,
    // result transactions
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // next_pc[8:0] status[10:9] written_value[42:11] compare_value[74:43]
    // finished[75] clean_end[76], rest zero
    output logic [trme_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    logic            f_valid, f_ready;
    trme_pkg::item_t f_item;
    logic            b_valid, b_ready;
    trme_pkg::item_t b_item;

    trme_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    // decouples decode from execution so the front keeps taking transactions
    trme_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    trme_back
    #(
        .NUM_REGS    (NUM_REGS),
        .STACK_DEPTH (STACK_DEPTH),
        .PROG_DEPTH  (PROG_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_item    (b_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

@@ src/trme_front.sv @@
// Front end: accepts instruction transactions and decodes the mode into an opcode.
`default_nettype none
module trme_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [trme_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   q_valid,
    input  wire logic                              q_ready,
    output trme_pkg::item_t                        q_item
);

    logic            valid_reg;
    trme_pkg::item_t item_reg;
    trme_pkg::item_t item_next;
    logic [trme_pkg::MODE_W-1:0] mode;

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;
    assign mode     = s_tdata[4:0];

    always_comb
    begin
        if (mode inside {[5'd0:trme_pkg::MODE_MAX]})
        begin
            item_next.op = trme_pkg::op_t'(mode);
        end
        else
        begin
            item_next.op = trme_pkg::OP_NOP;   // unused modes behave as nop
        end
        item_next.dst_reg     = s_tdata[9:5];
        item_next.src_is_reg  = s_tdata[10];
        item_next.src_reg     = s_tdata[15:11];
        item_next.src_imm     = s_tdata[47:16];
        item_next.left_is_reg = s_tdata[48];
        item_next.left_imm    = s_tdata[80:49];
        item_next.target      = s_tdata[88:81];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

@@ src/trme_queue.sv @@
// Two-entry queue of decoded instructions between front and back end.
`default_nettype none
module trme_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire trme_pkg::item_t  in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output trme_pkg::item_t       out_item
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    trme_pkg::item_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = cnt_reg != (PW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

@@ src/trme_div.sv @@
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module trme_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [trme_pkg::DATA_W-1:0]    dividend,
    input  wire logic [trme_pkg::DATA_W-1:0]    divisor,
    output logic                                done,
    output logic [trme_pkg::DATA_W-1:0]         quotient
);

    localparam int W  = trme_pkg::DATA_W;
    localparam int CW = $clog2(W+1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [W-1:0]  q_reg;      // dividend shifts out, quotient shifts in
    logic [W:0]    rem_reg;
    logic [W-1:0]  mb_reg;
    logic [W:0]    rem_sh;
    logic          fits;

    assign rem_sh   = {rem_reg[W-1:0], q_reg[W-1]};
    assign fits     = rem_sh >= {1'b0, mb_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - q_reg) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[W-1] ^ divisor[W-1];
            q_reg   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            mb_reg  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, mb_reg}) : rem_sh;
            q_reg   <= {q_reg[W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

@@ src/trme_back.sv @@
// Back end: register file, return stack, pc, compare state and result register.
`default_nettype none
module trme_back
#(
    parameter int NUM_REGS    = trme_pkg::DEF_NUM_REGS,
    parameter int STACK_DEPTH = trme_pkg::DEF_STACK_DEPTH,
    parameter int PROG_DEPTH  = trme_pkg::DEF_PROG_DEPTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    output logic                                   q_ready,
    input  wire trme_pkg::item_t                   q_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [trme_pkg::PLEN_W-1:0]       cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [trme_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int W   = trme_pkg::DATA_W;
    localparam int RAW = $clog2(NUM_REGS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int PCW = $clog2(PROG_DEPTH) + 1;
    localparam int CW  = (PCW > trme_pkg::PLEN_W) ? PCW : trme_pkg::PLEN_W;
    localparam logic [6:0] NREGS = 7'(NUM_REGS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EXEC = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [W-1:0]   rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic [PCW-1:0] stk_mem [STACK_DEPTH];
    logic           stk_bot_vld_reg;

    trme_pkg::item_t cur_reg;
    logic [W-1:0]   d_raw_reg, s_raw_reg;
    logic           d_ok_reg, s_ok_reg, d_in_rng_reg;
    logic [PCW-1:0] stk_raw_reg;
    logic           stk_zero_reg;
    logic [W-1:0]   d_reg, s_reg, l_reg, quot_reg;
    logic [PCW-1:0] stk_reg;

    logic [W-1:0]   cmp_reg;
    logic [PCW-1:0] pc_reg;
    logic [SCW-1:0] cnt_reg;
    logic [trme_pkg::PLEN_W-1:0] plen_reg;

    logic           out_valid_reg;
    logic [trme_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [W-1:0]   d_cur, s_cur, l_cur;
    logic           div_start, div_done;
    logic [W-1:0]   div_q;
    logic           commit;

    logic [W-1:0]   wv, wv_out, cmp_n;
    logic           we, take, push;
    trme_pkg::status_t stat;
    logic [PCW-1:0] nxt, seq;
    logic [SCW-1:0] cnt_n;
    logic           fin;

    assign cfg_ready = 1'b1;
    assign q_ready   = state_reg == ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // operands after valid-bit and range masking
    assign d_cur = d_ok_reg ? d_raw_reg : '0;
    assign s_cur = cur_reg.src_is_reg ? (s_ok_reg ? s_raw_reg : '0) : cur_reg.src_imm;
    assign l_cur = cur_reg.left_is_reg ? d_cur : cur_reg.left_imm;
    assign div_start = (state_reg == ST_READ) && (cur_reg.op == trme_pkg::OP_DIV)
                       && (s_cur != '0);

    trme_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d_cur),
        .divisor  (s_cur),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_READ;
            ST_READ: state_next = div_start ? ST_DIV : ST_EXEC;
            ST_DIV:  if (div_done) state_next = ST_EXEC;
            ST_EXEC: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // execute
    always_comb
    begin
        seq   = pc_reg + 1'b1;
        nxt   = seq;
        wv    = '0;
        we    = 1'b0;
        take  = 1'b0;
        push  = 1'b0;
        stat  = trme_pkg::STAT_OK;
        cmp_n = cmp_reg;
        cnt_n = cnt_reg;
        case (cur_reg.op)
            trme_pkg::OP_MOV: begin wv = s_reg; we = 1'b1; end
            trme_pkg::OP_INC: begin wv = d_reg + 1'b1; we = 1'b1; end
            trme_pkg::OP_DEC: begin wv = d_reg - 1'b1; we = 1'b1; end
            trme_pkg::OP_ADD: begin wv = d_reg + s_reg; we = 1'b1; end
            trme_pkg::OP_SUB: begin wv = d_reg - s_reg; we = 1'b1; end
            trme_pkg::OP_MUL: begin wv = d_reg * s_reg; we = 1'b1; end
            trme_pkg::OP_DIV:
            begin
                if (s_reg == '0)
                begin
                    stat = trme_pkg::STAT_DIVZ;
                end
                else
                begin
                    wv = quot_reg;
                    we = 1'b1;
                end
            end
            trme_pkg::OP_CMP: cmp_n = l_reg - s_reg;
            trme_pkg::OP_JMP: take = 1'b1;
            trme_pkg::OP_JNE: take = cmp_reg != '0;
            trme_pkg::OP_JE:  take = cmp_reg == '0;
            trme_pkg::OP_JGE: take = !cmp_reg[W-1];
            trme_pkg::OP_JG:  take = !cmp_reg[W-1] && (cmp_reg != '0);
            trme_pkg::OP_JLE: take = cmp_reg[W-1] || (cmp_reg == '0);
            trme_pkg::OP_JL:  take = cmp_reg[W-1];
            trme_pkg::OP_CALL:
            begin
                if (cnt_reg >= SCW'(STACK_DEPTH))
                begin
                    stat = trme_pkg::STAT_OVF;
                end
                else
                begin
                    push  = 1'b1;
                    cnt_n = cnt_reg + 1'b1;
                    take  = 1'b1;
                end
            end
            trme_pkg::OP_RET:
            begin
                if (cnt_reg == '0)
                begin
                    stat = trme_pkg::STAT_UNF;
                end
                else
                begin
                    cnt_n = cnt_reg - 1'b1;
                    nxt   = stk_reg;
                end
            end
            trme_pkg::OP_END:
            begin
                cnt_n = '0;
                nxt   = PCW'(plen_reg);
            end
            default: ;
        endcase
        if (take)
        begin
            nxt = PCW'(cur_reg.target);
        end
        we     = we && d_in_rng_reg;
        wv_out = we ? wv : d_reg;
        fin    = CW'(nxt) >= CW'(plen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rf_vld_reg      <= '0;
            stk_bot_vld_reg <= 1'b0;
            cmp_reg         <= '0;
            pc_reg          <= '0;
            cnt_reg         <= SCW'(1);
            plen_reg        <= trme_pkg::PLEN_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                plen_reg <= cfg_data;
            end
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                cmp_reg       <= cmp_n;
                pc_reg        <= nxt;
                cnt_reg       <= cnt_n;
                if (we)
                begin
                    rf_vld_reg[RAW'(cur_reg.dst_reg)] <= 1'b1;
                end
                if (push && (cnt_reg == '0))
                begin
                    stk_bot_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            cur_reg      <= q_item;
            d_raw_reg    <= rf_mem[RAW'(q_item.dst_reg)];
            s_raw_reg    <= rf_mem[RAW'(q_item.src_reg)];
            d_in_rng_reg <= {2'b00, q_item.dst_reg} < NREGS;
            d_ok_reg     <= ({2'b00, q_item.dst_reg} < NREGS)
                            && rf_vld_reg[RAW'(q_item.dst_reg)];
            s_ok_reg     <= ({2'b00, q_item.src_reg} < NREGS)
                            && rf_vld_reg[RAW'(q_item.src_reg)];
            stk_raw_reg  <= stk_mem[SAW'(cnt_reg - 1'b1)];
            stk_zero_reg <= (cnt_reg == SCW'(1)) && !stk_bot_vld_reg;
        end
        if (state_reg == ST_READ)
        begin
            d_reg   <= d_cur;
            s_reg   <= s_cur;
            l_reg   <= l_cur;
            stk_reg <= stk_zero_reg ? '0 : stk_raw_reg;
        end
        if (div_done)
        begin
            quot_reg <= div_q;
        end
        if (commit)
        begin
            if (we)
            begin
                rf_mem[RAW'(cur_reg.dst_reg)] <= wv;
            end
            if (push)
            begin
                stk_mem[SAW'(cnt_reg)] <= seq;
            end
            out_data_reg <= {3'b000, (cnt_n == '0), fin, cmp_n, wv_out, stat,
                             trme_pkg::PLEN_W'(nxt)};
        end
    end

endmodule
`default_nettype wire
